### src/lffc_pkg.sv
// Package for the light fade and flicker controller: widths, constants,
// opcodes, register indexes, state codes and the control/status structs.
// No dependencies.
`default_nettype none

package lffc_pkg;

    localparam int RAMP_TICKS = 96;
    localparam int RAMP_UNIT  = (2 * RAMP_TICKS + 2) / 3;
    localparam int RAMP_W     = $clog2(RAMP_TICKS + 1) + 1;
    localparam logic signed [RAMP_W-1:0] RAMP_TICKS_S = RAMP_W'(RAMP_TICKS);
    localparam logic signed [RAMP_W-1:0] RAMP_UNIT_S  = RAMP_W'(RAMP_UNIT);

    localparam int ENERGY_W   = 15;
    localparam int ENERGY_MAX = 25600;
    localparam int COLOR_W    = 8;
    localparam int DUR_W      = 16;
    localparam int LEFT_W     = DUR_W + 1;
    localparam int ALPHA_W    = 9;
    localparam int ALPHA_MAX  = 256;
    localparam int SAMPLE_W   = 10;
    localparam int FRAC_W     = 9;
    localparam int FLK_SPAN_W = 17;
    localparam int FLK_LEFT_W = FLK_SPAN_W + 1;
    localparam int FLICK_MAX  = 131071;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int NUM_JOBS      = 8;
    localparam int JOB_W         = 3;
    localparam int JOB_SPC_FIRST = 3;
    localparam logic [JOB_W-1:0] JOB_ENERGY  = JOB_W'(6);
    localparam logic [JOB_W-1:0] JOB_FLICKER = JOB_W'(7);

    localparam int DVD_W  = 32;
    localparam int DVS_W  = 17;
    localparam int QUOT_W = 16;
    localparam int CNT_W  = $clog2(QUOT_W);

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_ON        = 3'd1,
        OP_OFF       = 3'd2,
        OP_DIFFUSE   = 3'd3,
        OP_SPECULAR  = 3'd4,
        OP_LIGHTRAYS = 3'd5,
        OP_ENERGY    = 3'd6
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_ENERGY     = 3'd0,
        CFG_FLICKER_ENABLE     = 3'd1,
        CFG_FLICKER_AMOUNT     = 3'd2,
        CFG_FLICKER_TIME       = 3'd3,
        CFG_FLICKER_PAUSE_TIME = 3'd4,
        CFG_FLICKER_RANDOMNESS = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_JIT1,
        ST_JIT2,
        ST_JOB,
        ST_DIV,
        ST_COMMIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [2:0]                 opcode;
        logic [DUR_W-1:0]           duration;
        logic [COLOR_W-1:0]         red;
        logic [COLOR_W-1:0]         green;
        logic [COLOR_W-1:0]         blue;
        logic [ENERGY_W-1:0]        target_energy;
        logic                       rays_flag;
        logic signed [SAMPLE_W-1:0] random_sample;
    } item_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic [COLOR_W-1:0]  diffuse_red;
        logic [COLOR_W-1:0]  diffuse_green;
        logic [COLOR_W-1:0]  diffuse_blue;
        logic [COLOR_W-1:0]  specular_red;
        logic [COLOR_W-1:0]  specular_green;
        logic [COLOR_W-1:0]  specular_blue;
        logic [ALPHA_W-1:0]  sprite_alpha;
        logic                rays_on;
    } result_t;

    typedef struct packed {
        logic             load_item;
        logic             apply_cmd;
        logic             jit1;
        logic             jit2;
        logic             div_start;
        logic             div_store;
        logic             commit;
        logic             emit;
        logic [JOB_W-1:0] job;
    } ctrl_cmd_t;

    typedef struct packed {
        logic                is_tick;
        logic [NUM_JOBS-1:0] need;
        logic                div_done;
        logic                out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### src/lffc_if.sv
// Channel interfaces of the light fade and flicker controller: item input,
// result output and configuration write. Depends on lffc_pkg.
`default_nettype none

interface lffc_in_if;
    import lffc_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 opcode;
    logic [DUR_W-1:0]           duration;
    logic [COLOR_W-1:0]         red;
    logic [COLOR_W-1:0]         green;
    logic [COLOR_W-1:0]         blue;
    logic [ENERGY_W-1:0]        target_energy;
    logic                       rays_flag;
    logic signed [SAMPLE_W-1:0] random_sample;

    modport source (output valid, opcode, duration, red, green, blue, target_energy,
                    rays_flag, random_sample, input ready);
    modport sink (input valid, opcode, duration, red, green, blue, target_energy,
                  rays_flag, random_sample, output ready);
endinterface

interface lffc_out_if;
    import lffc_pkg::*;
    logic                valid;
    logic                ready;
    logic [ENERGY_W-1:0] energy;
    logic [COLOR_W-1:0]  diffuse_red;
    logic [COLOR_W-1:0]  diffuse_green;
    logic [COLOR_W-1:0]  diffuse_blue;
    logic [COLOR_W-1:0]  specular_red;
    logic [COLOR_W-1:0]  specular_green;
    logic [COLOR_W-1:0]  specular_blue;
    logic [ALPHA_W-1:0]  sprite_alpha;
    logic                rays_on;

    modport source (output valid, energy, diffuse_red, diffuse_green, diffuse_blue,
                    specular_red, specular_green, specular_blue, sprite_alpha, rays_on,
                    input ready);
    modport sink (input valid, energy, diffuse_red, diffuse_green, diffuse_blue,
                  specular_red, specular_green, specular_blue, sprite_alpha, rays_on,
                  output ready);
endinterface

interface lffc_cfg_if;
    import lffc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/light_fade_flicker_controller.sv
// Top level of the light fade and flicker controller: joins the controller
// and the datapath to the three channel interfaces. Depends on lffc_pkg,
// lffc_if, lffc_ctrl and lffc_datapath.
//
//   Channel   Direction  Word
//   in_ch     sink       opcode, duration, red, green, blue, target_energy,
//                        rays_flag, random_sample
//   out_ch    source     energy, diffuse and specular colors, sprite_alpha, rays_on
//   cfg_ch    sink       index, data (always ready)
//
// A command word passes through the apply and emit states to the result register.
// A tick passes through the jitter states JIT1 and JIT2, a divide on the shared
// 16-step serial divider for each active job (diffuse and specular channels,
// energy fade, flicker dip), then commit and emit.
// After reset all fades and ramps are inactive and the block is ready at once.
// A waiting result does not block the next word; a stalled output holds the
// controller only at the hand-off of the following result.
`default_nettype none

module light_fade_flicker_controller (
    input  logic        clk,
    input  logic        rst_n,
    lffc_in_if.sink     in_ch,
    lffc_out_if.source  out_ch,
    lffc_cfg_if.sink    cfg_ch
);
    import lffc_pkg::*;

    item_t      in_item;
    result_t    out_result;
    ctrl_cmd_t  cmd;
    dp_status_t sts;
    logic       in_ready;

    assign in_item.opcode        = in_ch.opcode;
    assign in_item.duration      = in_ch.duration;
    assign in_item.red           = in_ch.red;
    assign in_item.green         = in_ch.green;
    assign in_item.blue          = in_ch.blue;
    assign in_item.target_energy = in_ch.target_energy;
    assign in_item.rays_flag     = in_ch.rays_flag;
    assign in_item.random_sample = in_ch.random_sample;
    assign in_ch.ready           = in_ready;
    assign cfg_ch.ready          = 1'b1;

    lffc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lffc_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .cfg_we     (cfg_ch.valid),
        .cfg_index  (cfg_ch.index),
        .cfg_data   (cfg_ch.data),
        .out_ready  (out_ch.ready),
        .out_valid  (out_ch.valid),
        .out_result (out_result),
        .cmd        (cmd),
        .sts        (sts)
    );

    assign out_ch.energy         = out_result.energy;
    assign out_ch.diffuse_red    = out_result.diffuse_red;
    assign out_ch.diffuse_green  = out_result.diffuse_green;
    assign out_ch.diffuse_blue   = out_result.diffuse_blue;
    assign out_ch.specular_red   = out_result.specular_red;
    assign out_ch.specular_green = out_result.specular_green;
    assign out_ch.specular_blue  = out_result.specular_blue;
    assign out_ch.sprite_alpha   = out_result.sprite_alpha;
    assign out_ch.rays_on        = out_result.rays_on;

endmodule

`default_nettype wire

### src/lffc_div.sv
// Serial restoring divider, one quotient bit per cycle, shared by all fades
// and the flicker dip. Depends on lffc_pkg.
`default_nettype none

module lffc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lffc_pkg::DVD_W-1:0]   dividend,
    input  logic [lffc_pkg::DVS_W-1:0]   divisor,
    output logic                         done,
    output logic [lffc_pkg::QUOT_W-1:0]  quotient
);
    import lffc_pkg::*;

    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  rem_next;
    logic [QUOT_W-1:0] quo_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVS_W:0]    trial;
    logic              fits;

    // The caller guarantees that the quotient fits in QUOT_W bits, so the
    // upper half of the dividend is already below the divisor.
    assign trial    = {rem_reg, quo_reg[QUOT_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {{(DVS_W-(DVD_W-QUOT_W)){1'b0}}, dividend[DVD_W-1:QUOT_W]};
            quo_reg <= dividend[QUOT_W-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### src/lffc_datapath.sv
// Datapath of the light fade and flicker controller: configuration and effect
// state, operand selection, jitter multiplier, result register.
// Depends on lffc_pkg and lffc_div.
`default_nettype none

module lffc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lffc_pkg::item_t               in_item,
    input  logic                          cfg_we,
    input  logic [lffc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lffc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output lffc_pkg::result_t             out_result,
    input  lffc_pkg::ctrl_cmd_t           cmd,
    output lffc_pkg::dp_status_t          sts
);
    import lffc_pkg::*;

    function automatic logic [ENERGY_W-1:0] sat_energy(input logic [31:0] v);
        if (v > 32'(ENERGY_MAX))
            return ENERGY_W'(ENERGY_MAX);
        return v[ENERGY_W-1:0];
    endfunction

    function automatic logic [ENERGY_W-1:0] lerp(input logic [ENERGY_W-1:0] from,
                                                 input logic [ENERGY_W-1:0] to,
                                                 input logic [ENERGY_W-1:0] q,
                                                 input logic use_q);
        if (!use_q)
            return to;
        if (from >= to)
            return to + q;
        return to - q;
    endfunction

    // Configuration registers.
    logic [ENERGY_W-1:0]   init_reg;
    logic                  flk_en_reg;
    logic [FRAC_W-1:0]     flk_amt_reg;
    logic [DUR_W-1:0]      flk_time_reg;
    logic [DUR_W-1:0]      flk_pause_reg;
    logic [FRAC_W-1:0]     flk_rand_reg;

    // Effect state.
    logic [ENERGY_W-1:0]       energy_reg;
    logic signed [RAMP_W-1:0]  on_left_reg;
    logic signed [RAMP_W-1:0]  off_left_reg;
    logic [COLOR_W-1:0]        dif_now_reg [3];
    logic [COLOR_W-1:0]        dif_from_reg [3];
    logic [COLOR_W-1:0]        dif_to_reg [3];
    logic signed [LEFT_W-1:0]  dif_left_reg;
    logic [DUR_W-1:0]          dif_span_reg;
    logic [COLOR_W-1:0]        spc_now_reg [3];
    logic [COLOR_W-1:0]        spc_from_reg [3];
    logic [COLOR_W-1:0]        spc_to_reg [3];
    logic signed [LEFT_W-1:0]  spc_left_reg;
    logic [DUR_W-1:0]          spc_span_reg;
    logic [ENERGY_W-1:0]       efrom_reg;
    logic [ENERGY_W-1:0]       eto_reg;
    logic signed [LEFT_W-1:0]  eleft_reg;
    logic [DUR_W-1:0]          espan_reg;
    logic                      phase_reg;
    logic signed [FLK_LEFT_W-1:0] flk_left_reg;
    logic [FLK_SPAN_W-1:0]     flk_span_reg;
    logic                      rays_reg;
    logic [ALPHA_W-1:0]        alpha_reg;

    // Work registers.
    item_t                     item_reg;
    logic [QUOT_W-1:0]         q_reg [NUM_JOBS];
    logic [SAMPLE_W+FRAC_W-1:0] jit_p_reg;
    logic                      jit_neg_reg;
    logic [DUR_W+SAMPLE_W+FRAC_W-1:0] jit_m_reg;
    logic                      out_valid_reg;
    result_t                   out_reg;

    // Combinational terms.
    logic                      dif_use;
    logic                      spc_use;
    logic                      e_use;
    logic                      flk_need;
    logic [1:0]                cidx;
    logic [COLOR_W-1:0]        col_from;
    logic [COLOR_W-1:0]        col_to;
    logic [COLOR_W-1:0]        col_diff;
    logic [DUR_W-1:0]          col_left;
    logic [DUR_W-1:0]          col_span;
    logic [ENERGY_W-1:0]       e_diff;
    logic [DVD_W-1:0]          dvd;
    logic [DVS_W-1:0]          dvs;
    logic                      div_done;
    logic [QUOT_W-1:0]         div_q;
    logic signed [FLK_LEFT_W-1:0] flk_dec;
    logic signed [FLK_LEFT_W+1:0] flk_d;
    logic [FLK_LEFT_W:0]       flk_mag;
    logic [QUOT_W-1:0]         flk_param;
    logic signed [QUOT_W+1:0]  flk_factor_s;
    logic [FLK_SPAN_W-1:0]     flk_factor;
    logic [31:0]               flk_prod;
    logic [ENERGY_W-1:0]       flk_energy;
    logic [ALPHA_W-1:0]        flk_alpha;
    logic [DUR_W-1:0]          jit_base;
    logic [SAMPLE_W-1:0]       smag;
    logic [SAMPLE_W+FRAC_W-1:0] jit_q;
    logic signed [DUR_W+SAMPLE_W+FRAC_W-15:0] jit_t_s;
    logic [FLK_SPAN_W-1:0]     jit_t;
    logic [RAMP_W-2:0]         ramp_k;
    logic [ENERGY_W+RAMP_W-2:0] ramp_prod;
    logic [ENERGY_W-1:0]       ramp_energy;
    logic [ENERGY_W-1:0]       e_fade;
    logic [ENERGY_W-1:0]       energy_next;

    assign dif_use  = (dif_left_reg > 0) && (dif_span_reg != '0);
    assign spc_use  = (spc_left_reg > 0) && (spc_span_reg != '0);
    assign e_use    = (eleft_reg > 0) && (espan_reg != '0);
    assign flk_need = flk_en_reg && phase_reg && (flk_span_reg != '0);

    // Operand selection for the shared divider.
    always_comb
    begin
        cidx = 2'(cmd.job);
        if (cmd.job >= JOB_W'(JOB_SPC_FIRST))
            cidx = 2'(cmd.job - JOB_W'(JOB_SPC_FIRST));
        if (cmd.job >= JOB_W'(JOB_SPC_FIRST))
        begin
            col_from = spc_from_reg[cidx];
            col_to   = spc_to_reg[cidx];
            col_left = spc_left_reg[DUR_W-1:0];
            col_span = spc_span_reg;
        end
        else
        begin
            col_from = dif_from_reg[cidx];
            col_to   = dif_to_reg[cidx];
            col_left = dif_left_reg[DUR_W-1:0];
            col_span = dif_span_reg;
        end
        col_diff = (col_from >= col_to) ? col_from - col_to : col_to - col_from;
        e_diff   = (efrom_reg >= eto_reg) ? efrom_reg - eto_reg : eto_reg - efrom_reg;
        case (cmd.job)
            JOB_ENERGY:
            begin
                dvd = DVD_W'(e_diff * eleft_reg[DUR_W-1:0]);
                dvs = DVS_W'(espan_reg);
            end
            JOB_FLICKER:
            begin
                dvd = DVD_W'(flk_amt_reg * flk_mag);
                dvs = flk_span_reg;
            end
            default:
            begin
                dvd = DVD_W'(col_diff * col_left);
                dvs = DVS_W'(col_span);
            end
        endcase
    end

    lffc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // Flicker dip.
    assign flk_dec = flk_left_reg - FLK_LEFT_W'(1);
    assign flk_d   = $signed({flk_dec[FLK_LEFT_W-1], flk_dec, 1'b0})
                   - $signed({2'b00, 1'b0, flk_span_reg});
    assign flk_mag = flk_d[FLK_LEFT_W+1] ? (FLK_LEFT_W+1)'(-flk_d) : flk_d[FLK_LEFT_W:0];

    always_comb
    begin
        flk_param    = (flk_span_reg == '0) ? QUOT_W'(flk_amt_reg) : q_reg[JOB_FLICKER];
        flk_factor_s = (QUOT_W+2)'(ALPHA_MAX) - $signed({{(QUOT_W+2-FRAC_W){1'b0}}, flk_amt_reg})
                     + $signed({2'b00, flk_param});
        flk_factor   = flk_factor_s[QUOT_W+1] ? '0 : FLK_SPAN_W'(flk_factor_s);
        flk_prod     = 32'(init_reg) * 32'(flk_factor);
        if (phase_reg)
        begin
            flk_energy = sat_energy(flk_prod >> 8);
            flk_alpha  = (flk_factor > FLK_SPAN_W'(ALPHA_MAX)) ? ALPHA_W'(ALPHA_MAX)
                                                                 : flk_factor[ALPHA_W-1:0];
        end
        else
        begin
            flk_energy = sat_energy(32'(init_reg));
            flk_alpha  = ALPHA_W'(ALPHA_MAX);
        end
    end

    // Phase length jitter.
    assign jit_base = phase_reg ? flk_pause_reg : flk_time_reg;
    assign smag     = item_reg.random_sample[SAMPLE_W-1] ? SAMPLE_W'(-item_reg.random_sample)
                                                         : item_reg.random_sample;
    assign jit_q    = jit_m_reg[DUR_W+SAMPLE_W+FRAC_W-1:16];

    always_comb
    begin
        if (jit_neg_reg)
            jit_t_s = $signed({5'b0, jit_base}) - $signed({2'b00, jit_q});
        else
            jit_t_s = $signed({5'b0, jit_base}) + $signed({2'b00, jit_q});
        if (jit_t_s < 0)
            jit_t = '0;
        else if (jit_t_s > FLICK_MAX)
            jit_t = FLK_SPAN_W'(FLICK_MAX);
        else
            jit_t = jit_t_s[FLK_SPAN_W-1:0];
    end

    // On and off ramps.
    always_comb
    begin
        if (on_left_reg >= 0)
            ramp_k = (on_left_reg > RAMP_UNIT_S) ? '0
                                                  : (RAMP_W-1)'(RAMP_UNIT_S - on_left_reg);
        else
            ramp_k = off_left_reg[RAMP_W-2:0];
        ramp_prod   = init_reg * ramp_k;
        ramp_energy = sat_energy(32'(ramp_prod / RAMP_UNIT));
        e_fade      = lerp(efrom_reg, eto_reg, q_reg[JOB_ENERGY][ENERGY_W-1:0], e_use);
    end

    always_comb
    begin
        energy_next = energy_reg;
        if (on_left_reg >= 0 || off_left_reg >= 0)
            energy_next = ramp_energy;
        if (eleft_reg >= 0)
            energy_next = e_fade;
        if (flk_en_reg)
            energy_next = flk_energy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= ENERGY_W'(256);
            flk_en_reg    <= 1'b0;
            flk_amt_reg   <= FRAC_W'(128);
            flk_time_reg  <= DUR_W'(6);
            flk_pause_reg <= DUR_W'(32);
            flk_rand_reg  <= FRAC_W'(128);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INITIAL_ENERGY:     init_reg      <= cfg_data[ENERGY_W-1:0];
                CFG_FLICKER_ENABLE:     flk_en_reg    <= cfg_data[0];
                CFG_FLICKER_AMOUNT:     flk_amt_reg   <= cfg_data[FRAC_W-1:0];
                CFG_FLICKER_TIME:       flk_time_reg  <= cfg_data;
                CFG_FLICKER_PAUSE_TIME: flk_pause_reg <= cfg_data;
                CFG_FLICKER_RANDOMNESS: flk_rand_reg  <= cfg_data[FRAC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg   <= ENERGY_W'(256);
            on_left_reg  <= '1;
            off_left_reg <= '1;
            for (int c = 0; c < 3; c++)
            begin
                dif_now_reg[c]  <= '0;
                dif_from_reg[c] <= '0;
                dif_to_reg[c]   <= '0;
                spc_now_reg[c]  <= '0;
                spc_from_reg[c] <= '0;
                spc_to_reg[c]   <= '0;
            end
            dif_left_reg  <= '1;
            dif_span_reg  <= '0;
            spc_left_reg  <= '1;
            spc_span_reg  <= '0;
            efrom_reg     <= '0;
            eto_reg       <= '0;
            eleft_reg     <= '1;
            espan_reg     <= '0;
            phase_reg     <= 1'b0;
            flk_left_reg  <= '1;
            flk_span_reg  <= FLK_SPAN_W'(1);
            rays_reg      <= 1'b0;
            alpha_reg     <= ALPHA_W'(ALPHA_MAX);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.apply_cmd)
            begin
                case (item_reg.opcode)
                    OP_ON:
                    begin
                        off_left_reg <= '1;
                        on_left_reg  <= RAMP_TICKS_S;
                    end
                    OP_OFF:
                    begin
                        off_left_reg <= RAMP_TICKS_S;
                        on_left_reg  <= '1;
                    end
                    OP_DIFFUSE:
                    begin
                        for (int c = 0; c < 3; c++)
                            dif_from_reg[c] <= dif_now_reg[c];
                        dif_to_reg[0] <= item_reg.red;
                        dif_to_reg[1] <= item_reg.green;
                        dif_to_reg[2] <= item_reg.blue;
                        dif_span_reg  <= item_reg.duration;
                        dif_left_reg  <= {1'b0, item_reg.duration};
                    end
                    OP_SPECULAR:
                    begin
                        for (int c = 0; c < 3; c++)
                            spc_from_reg[c] <= spc_now_reg[c];
                        spc_to_reg[0] <= item_reg.red;
                        spc_to_reg[1] <= item_reg.green;
                        spc_to_reg[2] <= item_reg.blue;
                        spc_span_reg  <= item_reg.duration;
                        spc_left_reg  <= {1'b0, item_reg.duration};
                    end
                    OP_LIGHTRAYS:
                        rays_reg <= item_reg.rays_flag;
                    OP_ENERGY:
                    begin
                        efrom_reg <= energy_reg;
                        eto_reg   <= sat_energy(32'(item_reg.target_energy));
                        espan_reg <= item_reg.duration;
                        eleft_reg <= {1'b0, item_reg.duration};
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.commit)
            begin
                energy_reg <= energy_next;
                if (on_left_reg >= 0)
                    on_left_reg <= on_left_reg - RAMP_W'(1);
                else if (off_left_reg >= 0)
                    off_left_reg <= off_left_reg - RAMP_W'(1);
                if (dif_left_reg >= 0)
                begin
                    for (int c = 0; c < 3; c++)
                        dif_now_reg[c] <= COLOR_W'(lerp(ENERGY_W'(dif_from_reg[c]),
                                                        ENERGY_W'(dif_to_reg[c]),
                                                        q_reg[c][ENERGY_W-1:0], dif_use));
                    dif_left_reg <= dif_left_reg - LEFT_W'(1);
                end
                if (spc_left_reg >= 0)
                begin
                    for (int c = 0; c < 3; c++)
                        spc_now_reg[c] <= COLOR_W'(lerp(ENERGY_W'(spc_from_reg[c]),
                                          ENERGY_W'(spc_to_reg[c]),
                                          q_reg[JOB_W'(JOB_SPC_FIRST + c)][ENERGY_W-1:0],
                                          spc_use));
                    spc_left_reg <= spc_left_reg - LEFT_W'(1);
                end
                if (eleft_reg >= 0)
                    eleft_reg <= eleft_reg - LEFT_W'(1);
                if (flk_en_reg)
                begin
                    alpha_reg <= flk_alpha;
                    if (flk_dec < 0)
                    begin
                        phase_reg    <= ~phase_reg;
                        flk_left_reg <= {1'b0, jit_t};
                        flk_span_reg <= jit_t;
                    end
                    else
                    begin
                        flk_left_reg <= flk_dec;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_item;
        if (cmd.jit1)
        begin
            jit_p_reg   <= smag * flk_rand_reg;
            jit_neg_reg <= item_reg.random_sample[SAMPLE_W-1];
        end
        if (cmd.jit2)
            jit_m_reg <= jit_base * jit_p_reg;
        if (cmd.div_store)
            q_reg[cmd.job] <= div_q;
        if (cmd.emit)
        begin
            out_reg.energy         <= energy_reg;
            out_reg.diffuse_red    <= dif_now_reg[0];
            out_reg.diffuse_green  <= dif_now_reg[1];
            out_reg.diffuse_blue   <= dif_now_reg[2];
            out_reg.specular_red   <= spc_now_reg[0];
            out_reg.specular_green <= spc_now_reg[1];
            out_reg.specular_blue  <= spc_now_reg[2];
            out_reg.sprite_alpha   <= alpha_reg;
            out_reg.rays_on        <= rays_reg;
        end
    end

    assign sts.is_tick  = (in_item.opcode == OP_TICK);
    assign sts.need     = {flk_need, e_use, {3{spc_use}}, {3{dif_use}}};
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

`default_nettype wire

### src/lffc_ctrl.sv
// Controller of the light fade and flicker controller: sequences command
// application, jitter, the divider jobs, commit and result hand-off.
// Depends on lffc_pkg.
`default_nettype none

module lffc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lffc_pkg::dp_status_t sts,
    output lffc_pkg::ctrl_cmd_t  cmd
);
    import lffc_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [JOB_W-1:0] job_reg;
    logic [JOB_W-1:0] job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = sts.is_tick ? ST_JIT1 : ST_CMD;
            ST_CMD:
                state_next = ST_EMIT;
            ST_JIT1:
                state_next = ST_JIT2;
            ST_JIT2:
            begin
                state_next = ST_JOB;
                job_next   = '0;
            end
            ST_JOB:
            begin
                if (sts.need[job_reg])
                    state_next = ST_DIV;
                else if (job_reg == JOB_FLICKER)
                    state_next = ST_COMMIT;
                else
                    job_next = job_reg + 1'b1;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    if (job_reg == JOB_FLICKER)
                        state_next = ST_COMMIT;
                    else
                    begin
                        state_next = ST_JOB;
                        job_next   = job_reg + 1'b1;
                    end
                end
            end
            ST_COMMIT:
                state_next = ST_EMIT;
            ST_EMIT:
                if (sts.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        cmd.job = job_reg;
        case (state_reg)
            ST_IDLE:   cmd.load_item = in_valid;
            ST_CMD:    cmd.apply_cmd = 1'b1;
            ST_JIT1:   cmd.jit1      = 1'b1;
            ST_JIT2:   cmd.jit2      = 1'b1;
            ST_JOB:    cmd.div_start = sts.need[job_reg];
            ST_DIV:    cmd.div_store = sts.div_done;
            ST_COMMIT: cmd.commit    = 1'b1;
            ST_EMIT:   cmd.emit      = sts.out_free;
            default:
            begin
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    a_cmd_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMD |=> state_reg == ST_EMIT)
        else $error("command item did not go straight to result hand-off");

    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && !sts.div_done) |=> (state_reg == ST_DIV && $stable(job_reg)))
        else $error("job changed while the divider was busy");

    a_jobs_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_JIT2 |=> (state_reg == ST_JOB && job_reg == '0))
        else $error("tick job sequence did not start at the first job");

    a_start_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == ST_DIV)
        else $error("divider started outside the job state");

endmodule

`default_nettype wire
